@@ src/nsd_pkg.sv @@
// Package for the netstring stream decoder: widths, phase and status codes,
// and the item and result structs used by the modules. No dependencies.
package nsd_pkg;

  localparam int WINDOW    = 32;  // colon must appear within this many bytes
  localparam int LEN_WIDTH = 32;  // length digits may not exceed this many bits
  localparam int MIN_BYTES = 3;   // shortest buffer that can hold a netstring

  localparam int POS_W  = $clog2(WINDOW + 1);  // position counter saturates at WINDOW
  localparam int MUL_W  = LEN_WIDTH + 4;       // room for length * 10 + digit
  localparam int DLEN_W = 32;                  // width of the reported length

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    PH_DIGITS,
    PH_PAYLOAD,
    PH_COMMA,
    PH_HOLD,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NO_COLON = 3'd2,
    ST_BAD_DIG  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_TRUNC    = 3'd6,
    ST_NO_COMMA = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              payload_valid;
    logic              payload_last;
    logic              verdict_valid;
    status_t           status;
    logic [DLEN_W-1:0] decoded_length;
  } result_t;

endpackage

@@ src/nsd_in_stage.sv @@
// Input register of the netstring stream decoder: holds one accepted byte
// until the parser consumes it. Depends on nsd_pkg.
module nsd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  nsd_pkg::in_item_t in_item,
  input  logic             take,       // parser consumes the held item
  output logic             held_valid,
  output nsd_pkg::in_item_t held_item
);

  logic              valid_r, valid_nxt;
  nsd_pkg::in_item_t item_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

@@ src/nsd_parser.sv @@
// Netstring parser: phase state machine, length accumulator, payload
// counter and verdict logic; one byte per step. Depends on nsd_pkg.
module nsd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  nsd_pkg::in_item_t item,
  output nsd_pkg::result_t  res
);

  nsd_pkg::phase_t              phase_r, phase_nxt;
  logic [nsd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [nsd_pkg::LEN_WIDTH-1:0] len_r, len_nxt;
  logic [nsd_pkg::LEN_WIDTH-1:0] rem_r, rem_nxt;
  logic                          nd_r, nd_nxt;
  logic                          ov_r, ov_nxt;
  logic                          given_r, given_nxt;
  nsd_pkg::status_t              held_r, held_nxt;

  // Step intermediates shared by the next-state and output blocks.
  logic [nsd_pkg::MUL_W-1:0] acc_ext;
  logic [nsd_pkg::MUL_W-1:0] acc_sum;
  logic                      is_digit;
  logic                      fire;
  nsd_pkg::status_t          fire_st;
  logic [nsd_pkg::LEN_WIDTH-1:0] len_step;

  logic [7:0] b;
  assign b        = item.data_byte;
  assign is_digit = (b >= nsd_pkg::CHAR_ZERO) && (b <= nsd_pkg::CHAR_NINE);
  assign acc_ext  = nsd_pkg::MUL_W'(len_r);
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + nsd_pkg::MUL_W'(b[3:0]);

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    nd_nxt    = nd_r;
    ov_nxt    = ov_r;
    given_nxt = given_r;
    held_nxt  = held_r;
    fire      = 1'b0;
    fire_st   = nsd_pkg::ST_OK;
    len_step  = len_r;

    unique case (phase_r)
      nsd_pkg::PH_DIGITS: begin
        if (b == nsd_pkg::CHAR_COLON) begin
          if (nd_r) begin
            held_nxt  = nsd_pkg::ST_BAD_DIG;
            phase_nxt = nsd_pkg::PH_HOLD;
          end else if (pos_r == '0) begin
            held_nxt  = nsd_pkg::ST_EMPTY;
            phase_nxt = nsd_pkg::PH_HOLD;
          end else if (ov_r) begin
            held_nxt  = nsd_pkg::ST_OVERFLOW;
            phase_nxt = nsd_pkg::PH_HOLD;
          end else begin
            rem_nxt   = len_r;
            phase_nxt = (len_r != '0) ? nsd_pkg::PH_PAYLOAD : nsd_pkg::PH_COMMA;
          end
        end else if (!is_digit) begin
          nd_nxt = 1'b1;
        end else if (!nd_r && !ov_r) begin
          // Saturate once the value no longer fits in LEN_WIDTH bits.
          if (acc_sum[nsd_pkg::MUL_W-1:nsd_pkg::LEN_WIDTH] != '0) begin
            ov_nxt  = 1'b1;
            len_nxt = nsd_pkg::LEN_MAX;
          end else begin
            len_nxt = acc_sum[nsd_pkg::LEN_WIDTH-1:0];
          end
        end
      end
      nsd_pkg::PH_PAYLOAD: begin
        rem_nxt = rem_r - 1'b1;
        if (rem_r == nsd_pkg::LEN_WIDTH'(1)) begin
          phase_nxt = nsd_pkg::PH_COMMA;
        end
      end
      nsd_pkg::PH_COMMA: begin
        held_nxt  = (b == nsd_pkg::CHAR_COMMA) ? nsd_pkg::ST_OK : nsd_pkg::ST_NO_COMMA;
        phase_nxt = nsd_pkg::PH_HOLD;
      end
      nsd_pkg::PH_HOLD, nsd_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    len_step = len_nxt;

    if (pos_r != nsd_pkg::POS_W'(nsd_pkg::WINDOW)) begin
      pos_nxt = pos_r + 1'b1;
    end

    if (phase_nxt == nsd_pkg::PH_DIGITS && pos_nxt >= nsd_pkg::POS_W'(nsd_pkg::WINDOW)) begin
      held_nxt  = nsd_pkg::ST_NO_COLON;
      phase_nxt = nsd_pkg::PH_HOLD;
    end

    // A held verdict is released once the minimum length has passed.
    if (phase_nxt == nsd_pkg::PH_HOLD && pos_nxt >= nsd_pkg::POS_W'(nsd_pkg::MIN_BYTES)) begin
      fire      = 1'b1;
      fire_st   = held_nxt;
      phase_nxt = nsd_pkg::PH_DONE;
      given_nxt = 1'b1;
    end

    if (item.buffer_end) begin
      if (!given_nxt) begin
        fire = 1'b1;
        if (pos_nxt < nsd_pkg::POS_W'(nsd_pkg::MIN_BYTES)) begin
          fire_st = nsd_pkg::ST_SHORT;
        end else if (phase_nxt == nsd_pkg::PH_DIGITS) begin
          fire_st = nsd_pkg::ST_NO_COLON;
        end else if (phase_nxt == nsd_pkg::PH_HOLD) begin
          fire_st = held_nxt;
        end else begin
          fire_st = nsd_pkg::ST_TRUNC;
        end
      end
      phase_nxt = nsd_pkg::PH_DIGITS;
      pos_nxt   = '0;
      len_nxt   = '0;
      rem_nxt   = '0;
      nd_nxt    = 1'b0;
      ov_nxt    = 1'b0;
      given_nxt = 1'b0;
      held_nxt  = nsd_pkg::ST_OK;
    end
  end

  // Outputs.
  always_comb begin
    res = '0;
    if (phase_r == nsd_pkg::PH_PAYLOAD) begin
      res.payload_byte  = b;
      res.payload_valid = 1'b1;
      res.payload_last  = (rem_r == nsd_pkg::LEN_WIDTH'(1));
    end
    res.verdict_valid = fire;
    res.status        = fire ? fire_st : nsd_pkg::ST_OK;
    if (fire) begin
      case (fire_st)
        nsd_pkg::ST_OK, nsd_pkg::ST_TRUNC, nsd_pkg::ST_NO_COMMA:
          res.decoded_length = nsd_pkg::DLEN_W'(len_step);
        nsd_pkg::ST_OVERFLOW:
          res.decoded_length = nsd_pkg::DLEN_W'(nsd_pkg::LEN_MAX);
        default:
          res.decoded_length = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nsd_pkg::PH_DIGITS;
      pos_r   <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      nd_r    <= 1'b0;
      ov_r    <= 1'b0;
      given_r <= 1'b0;
      held_r  <= nsd_pkg::ST_OK;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      nd_r    <= nd_nxt;
      ov_r    <= ov_nxt;
      given_r <= given_nxt;
      held_r  <= held_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.buffer_end |=> phase_r == nsd_pkg::PH_DIGITS && pos_r == '0 && !given_r)
    else $error("state not cleared after buffer end");

  a_done_given: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == nsd_pkg::PH_DONE |-> given_r)
    else $error("done phase without a verdict");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == nsd_pkg::PH_PAYLOAD |-> rem_r != '0)
    else $error("payload phase with nothing left");

  a_single_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.verdict_valid |-> !given_r)
    else $error("second verdict in one buffer");
`endif

endmodule

@@ src/nsd_out_stage.sv @@
// Result register of the netstring stream decoder: holds one result item
// and packs it onto the master-side stream. Depends on nsd_pkg.
module nsd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  nsd_pkg::result_t res,
  output logic             free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,
  output logic [4:0]       out_tuser,
  output logic             out_tlast
);

  logic             valid_r, valid_nxt;
  nsd_pkg::result_t res_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = free ? load : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.decoded_length, res_r.payload_byte};
  assign out_tuser  = {res_r.status, res_r.verdict_valid, res_r.payload_valid};
  assign out_tlast  = res_r.payload_last;

endmodule

@@ src/netstring_stream_decoder_top.sv @@
// Top level of the netstring stream decoder: input register, parser and
// result register. Depends on nsd_pkg, nsd_in_stage, nsd_parser, nsd_out_stage.
//
//  Channel  Direction  Ports                            Contents
//  in_      slave      in_tvalid/tready/tdata/tlast     one buffer byte, tlast = buffer end
//  out_     master     out_tvalid/tready/tdata/tuser/   one result item per input item
//                      tlast
//
// Each input item yields exactly one result item, by way of the input and
// result registers; one item can be accepted every cycle unless out_tready stalls,
// a rate set by the single parser step between the two registers.
// Reset (rst_n low at a clock edge) empties both registers and returns the
// parser to the length-digit phase. A stall on out_tready holds the result
// register, then the input register, and then drops in_tready.
module netstring_stream_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] payload_byte, [39:8] decoded_length
  output logic [4:0]  out_tuser,  // [0] payload_valid, [1] verdict_valid, [4:2] status
  output logic        out_tlast   // payload_last
);

  nsd_pkg::in_item_t in_item;
  nsd_pkg::in_item_t held_item;
  nsd_pkg::result_t  res;
  logic              held_valid;
  logic              out_free;
  logic              step_en;

  assign in_item.data_byte  = in_tdata;
  assign in_item.buffer_end = in_tlast;

  // The parser advances whenever a held byte exists and the result
  // register can take what it produces.
  assign step_en = held_valid && out_free;

  nsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (out_free),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  nsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (held_item),
    .res     (res)
  );

  nsd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
